FILE: rtl/wcpg_pkg.sv
`timescale 1ns / 1ps

package wcpg_pkg;

  // Fixed field widths of the event and result items.
  localparam int PID_W      = 31;
  localparam int DAY_W      = 16;
  localparam int OUT_WORD_W = 24;

  // Configuration port layout.
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;

  // Register indexes (word address = byte address / 4).
  localparam logic REG_WINDOW_DAYS = 1'b0;

  // Reset value of the window register.
  localparam logic [DAY_W-1:0] WINDOW_DAYS_RESET = 16'd7;

  // Sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EVICT,
    ST_SCAN,
    ST_FLUSH
  } wcpg_state_t;

  // Commands from the sequencer to the datapath.
  typedef struct packed {
    logic load;
    logic evict;
    logic start_scan;
    logic scan_step;
    logic finish;
  } wcpg_cmd_t;

  // Status from the datapath to the sequencer.
  typedef struct packed {
    logic evict_hit;
    logic scan_done;
    logic scan_hold;
    logic out_free;
  } wcpg_status_t;

endpackage

FILE: rtl/wcpg_ctrl.sv
`timescale 1ns / 1ps

module wcpg_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  wcpg_pkg::wcpg_status_t status,
  output wcpg_pkg::wcpg_cmd_t    cmd
);
  import wcpg_pkg::*;

  wcpg_state_t state_r;
  wcpg_state_t state_nxt;

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next-state logic.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_EVICT;
        end
      end
      ST_EVICT: begin
        if (!status.evict_hit) begin
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (status.scan_done) begin
          state_nxt = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        if (status.out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Command outputs.
  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    unique case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        cmd.load = in_valid;
      end
      ST_EVICT: begin
        cmd.evict      = status.evict_hit;
        cmd.start_scan = !status.evict_hit;
      end
      ST_SCAN: begin
        cmd.scan_step = !status.scan_done && !status.scan_hold;
      end
      ST_FLUSH: begin
        cmd.finish = status.out_free;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

endmodule

FILE: rtl/wcpg_dp.sv
`timescale 1ns / 1ps

module wcpg_dp #(
  parameter int WINDOW_DEPTH = 32,
  parameter int WORD_BITS    = 24
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  wcpg_pkg::wcpg_cmd_t                  cmd,
  output wcpg_pkg::wcpg_status_t               status,
  input  logic [wcpg_pkg::DAY_W-1:0]          window_days,
  input  logic [wcpg_pkg::PID_W-1:0]          in_patient_id,
  input  logic [wcpg_pkg::DAY_W-1:0]          in_day,
  input  logic [wcpg_pkg::OUT_WORD_W-1:0]     in_word,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic                                out_pair_valid,
  output logic [wcpg_pkg::OUT_WORD_W-1:0]     out_word_low,
  output logic [wcpg_pkg::OUT_WORD_W-1:0]     out_word_high,
  output logic                                out_dropped,
  output logic                                out_last
);
  import wcpg_pkg::*;

  localparam int PW = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int FW = $clog2(WINDOW_DEPTH + 1);
  localparam int SW = (WORD_BITS < OUT_WORD_W) ? WORD_BITS : OUT_WORD_W;

  // Circular slot index: (base + offset) mod depth, one compare and subtract.
  function automatic logic [PW-1:0] slot_of(input logic [PW-1:0] base,
                                            input logic [FW-1:0] ofs);
    logic [FW:0] sum;
    sum = (FW+1)'(base) + (FW+1)'(ofs);
    if (sum >= (FW+1)'(WINDOW_DEPTH)) begin
      sum = sum - (FW+1)'(WINDOW_DEPTH);
    end
    return sum[PW-1:0];
  endfunction

  function automatic logic [PW-1:0] slot_inc(input logic [PW-1:0] base);
    return (base == PW'(WINDOW_DEPTH - 1)) ? '0 : base + PW'(1);
  endfunction

  // Window store.
  logic [DAY_W-1:0] mem_day  [WINDOW_DEPTH];
  logic [SW-1:0]    mem_word [WINDOW_DEPTH];
  logic [DAY_W-1:0] rd_day_r;
  logic [SW-1:0]    rd_word_r;
  logic [PW-1:0]    rd_addr;
  logic [PW-1:0]    wr_addr;

  // Control registers.
  logic [PID_W-1:0] cur_pid_r, cur_pid_nxt;
  logic             have_r, have_nxt;
  logic [PW-1:0]    oldest_r, oldest_nxt;
  logic [FW-1:0]    fill_r, fill_nxt;
  logic [FW-1:0]    k_r, k_nxt;
  logic             drop_r, drop_nxt;
  logic             pend_v_r, pend_v_nxt;
  logic             out_valid_r, out_valid_nxt;

  // Payload registers.
  logic [DAY_W-1:0] day_r;
  logic [SW-1:0]    word_r;
  logic [SW-1:0]    pend_lo_r, pend_hi_r;
  logic             out_pv_r, out_drop_r, out_last_r;
  logic [SW-1:0]    out_lo_r, out_hi_r;

  logic             new_patient;
  logic             in_win;
  logic             out_free;
  logic             push;
  logic [SW-1:0]    pair_lo, pair_hi;

  // Day window test shared by eviction and scan; a later stored day counts as inside.
  assign in_win = ({1'b0, day_r} <= ({1'b0, rd_day_r} + {1'b0, window_days}));

  assign new_patient = !have_r || (in_patient_id != cur_pid_r);
  assign out_free    = !out_valid_r || !out_stall;

  // Ordered pair of the current event's word and the stored word.
  assign pair_lo = (word_r < rd_word_r) ? word_r : rd_word_r;
  assign pair_hi = (word_r < rd_word_r) ? rd_word_r : word_r;

  assign status.evict_hit = (fill_r != '0) && !in_win;
  assign status.scan_done = (k_r == fill_r);
  assign status.scan_hold = in_win && pend_v_r && !out_free;
  assign status.out_free  = out_free;

  // A result leaves when a new match displaces the pending pair, or at the end.
  assign push = (cmd.scan_step && in_win && pend_v_r) || cmd.finish;

  // Next values of the control registers.
  always_comb begin
    cur_pid_nxt = cur_pid_r;
    have_nxt    = have_r;
    oldest_nxt  = oldest_r;
    fill_nxt    = fill_r;
    k_nxt       = k_r;
    drop_nxt    = drop_r;
    pend_v_nxt  = pend_v_r;
    if (cmd.load) begin
      k_nxt      = '0;
      pend_v_nxt = 1'b0;
      if (new_patient) begin
        cur_pid_nxt = in_patient_id;
        have_nxt    = 1'b1;
        oldest_nxt  = '0;
        fill_nxt    = '0;
      end
    end
    if (cmd.evict) begin
      oldest_nxt = slot_inc(oldest_r);
      fill_nxt   = fill_r - FW'(1);
    end
    if (cmd.start_scan) begin
      drop_nxt = (fill_r == FW'(WINDOW_DEPTH));
    end
    if (cmd.scan_step) begin
      k_nxt = k_r + FW'(1);
      if (in_win) begin
        pend_v_nxt = 1'b1;
      end
    end
    if (cmd.finish) begin
      pend_v_nxt = 1'b0;
      if (drop_r) begin
        oldest_nxt = slot_inc(oldest_r);
      end else begin
        fill_nxt = fill_r + FW'(1);
      end
    end
  end

  assign out_valid_nxt = push || (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_pid_r   <= '0;
      have_r      <= 1'b0;
      oldest_r    <= '0;
      fill_r      <= '0;
      k_r         <= '0;
      drop_r      <= 1'b0;
      pend_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      cur_pid_r   <= cur_pid_nxt;
      have_r      <= have_nxt;
      oldest_r    <= oldest_nxt;
      fill_r      <= fill_nxt;
      k_r         <= k_nxt;
      drop_r      <= drop_nxt;
      pend_v_r    <= pend_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Event capture and pending pair.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      day_r  <= in_day;
      word_r <= in_word[SW-1:0];
    end
    if (cmd.scan_step && in_win) begin
      pend_lo_r <= pair_lo;
      pend_hi_r <= pair_hi;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (push) begin
      out_drop_r <= drop_r;
      if (cmd.finish) begin
        out_pv_r   <= pend_v_r;
        out_lo_r   <= pend_v_r ? pend_lo_r : '0;
        out_hi_r   <= pend_v_r ? pend_hi_r : '0;
        out_last_r <= 1'b1;
      end else begin
        out_pv_r   <= 1'b1;
        out_lo_r   <= pend_lo_r;
        out_hi_r   <= pend_hi_r;
        out_last_r <= 1'b0;
      end
    end
  end

  // The read address follows the next scan position so data lands as it is needed.
  assign rd_addr = slot_of(oldest_nxt, k_nxt);
  assign wr_addr = drop_r ? oldest_r : slot_of(oldest_r, fill_r);

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      mem_day[wr_addr]  <= day_r;
      mem_word[wr_addr] <= word_r;
    end
    rd_day_r  <= mem_day[rd_addr];
    rd_word_r <= mem_word[rd_addr];
  end

  assign out_valid      = out_valid_r;
  assign out_pair_valid = out_pv_r;
  assign out_word_low   = OUT_WORD_W'(out_lo_r);
  assign out_word_high  = OUT_WORD_W'(out_hi_r);
  assign out_dropped    = out_drop_r;
  assign out_last       = out_last_r;

endmodule

FILE: rtl/windowed_cooccurrence_pair_generator_top.sv
`timescale 1ns / 1ps

// Emits co-occurrence pairs for a stream of events sorted by patient and day.
// Each accepted event produces one transaction per stored event of the same
// patient within window_days (smaller word first), oldest first, or a single
// transaction with out_pair_valid low when nothing matches; out_last marks the
// final one and out_dropped flags events that pushed an entry out of a full
// store. After acceptance an event passes through eviction of the oldest entries
// that lie outside the window, a scan of the entries left and a flush of the
// last result; stalls on the result side lengthen the scan and the flush. The
// entries evicted and those left to scan never exceed WINDOW_DEPTH together.
// The single read port of the window store, which the sequencer walks one
// entry per cycle while the result side does not stall, sets the pace. The
// input is stalled from acceptance until the last result is handed to the
// output register. window_days resets to 7 and is written at byte address 0.
module windowed_cooccurrence_pair_generator_top #(
  parameter int WINDOW_DEPTH = 32,
  parameter int WORD_BITS    = 24
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [wcpg_pkg::PID_W-1:0]          in_patient_id,
  input  logic [wcpg_pkg::DAY_W-1:0]          in_day,
  input  logic [wcpg_pkg::OUT_WORD_W-1:0]     in_word,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic                                out_pair_valid,
  output logic [wcpg_pkg::OUT_WORD_W-1:0]     out_word_low,
  output logic [wcpg_pkg::OUT_WORD_W-1:0]     out_word_high,
  output logic                                out_dropped,
  output logic                                out_last,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [wcpg_pkg::CFG_ADDR_W-1:0]     paddr,
  input  logic [wcpg_pkg::CFG_DATA_W-1:0]     pwdata,
  output logic [wcpg_pkg::CFG_DATA_W-1:0]     prdata,
  output logic                                pready
);
  import wcpg_pkg::*;

  logic [DAY_W-1:0] window_r;
  logic             reg_sel;
  wcpg_cmd_t        cmd;
  wcpg_status_t     status;

  // Register file: one window register, access never waits (pready held high).
  assign pready  = 1'b1;
  assign reg_sel = (paddr[2] == REG_WINDOW_DAYS);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_r <= WINDOW_DAYS_RESET;
    end else if (psel && penable && pwrite && pready && reg_sel) begin
      window_r <= pwdata[DAY_W-1:0];
    end
  end

  assign prdata = reg_sel ? CFG_DATA_W'(window_r) : '0;

  // Sequencer.
  wcpg_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  // Window store, scan and result datapath.
  wcpg_dp #(
    .WINDOW_DEPTH (WINDOW_DEPTH),
    .WORD_BITS    (WORD_BITS)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .status         (status),
    .window_days    (window_r),
    .in_patient_id  (in_patient_id),
    .in_day         (in_day),
    .in_word        (in_word),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_pair_valid (out_pair_valid),
    .out_word_low   (out_word_low),
    .out_word_high  (out_word_high),
    .out_dropped    (out_dropped),
    .out_last       (out_last)
  );

endmodule

FILE: rtl/wcpg_checker.sv
`timescale 1ns / 1ps

module wcpg_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_valid,
  input logic                            in_stall,
  input logic                            out_valid,
  input logic                            out_stall,
  input logic                            out_pair_valid,
  input logic [wcpg_pkg::OUT_WORD_W-1:0] out_word_low,
  input logic [wcpg_pkg::OUT_WORD_W-1:0] out_word_high,
  input logic                            out_dropped,
  input logic                            out_last
);

  // A stalled result transaction holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_pair_valid) &&
      $stable(out_word_low) && $stable(out_word_high) &&
      $stable(out_dropped) && $stable(out_last))
    else $error("stalled result changed");

  // One event at a time: the input is busy right after a transaction.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input not stalled after accepting an event");

  // A result without a pair is always the only and final one.
  a_empty_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_pair_valid |-> out_last)
    else $error("empty result without last");

  // A result without a pair carries zero words.
  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_pair_valid |-> (out_word_low == '0) && (out_word_high == '0))
    else $error("empty result with nonzero words");

  // Pairs are ordered.
  a_pair_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_pair_valid |-> out_word_low <= out_word_high)
    else $error("pair words out of order");

endmodule

bind windowed_cooccurrence_pair_generator_top wcpg_checker u_wcpg_checker (.*);
